/* src/uyvy_yuv_to_rgb_converter_core_defines.svh */
// Assertion macros shared by the converter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef UYVY_YUV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define UYVY_YUV_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Check a property on every rising clock edge, disabled while in reset.
`define UYC_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define UYC_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error(msg);

`endif

/* src/uyc_pkg.sv */
// Package for the UYVY/YUV to RGB converter: format codes, coefficients
// and the fixed-point coefficient helper. No dependencies.
`default_nettype none

package uyc_pkg;

	localparam int COEF_FRAC_BITS_DEF = 16;

	// input_format register codes
	localparam logic FMT_UYVY    = 1'b0;
	localparam logic FMT_TRIPLET = 1'b1;
	localparam logic FMT_RESET   = FMT_UYVY;

	// coefficients in thousandths
	localparam int unsigned Y_MILLI  = 1164;
	localparam int unsigned RV_MILLI = 1596;
	localparam int unsigned GV_MILLI = 813;
	localparam int unsigned GU_MILLI = 391;
	localparam int unsigned BU_MILLI = 2018;

	localparam int LUMA_OFFSET   = 16;
	localparam int CHROMA_OFFSET = 128;
	localparam int CHAN_MAX      = 255;

	// round(milli / 1000 * 2^frac), ties up; evaluated at elaboration
	function automatic longint coef_milli(input int unsigned milli, input int unsigned frac);
		longint scaled;
		scaled = longint'(milli) << frac;
		return (scaled + 64'sd500) / 64'sd1000;
	endfunction

endpackage

`default_nettype wire

/* src/uyvy_yuv_to_rgb_converter_core.sv */
// Top level of the studio-range BT.601 YUV to RGB converter.
// Depends on uyc_pkg and uyvy_yuv_to_rgb_converter_core_defines.svh.
//
// Usage:
//   Command channel: an item (u_sample, y_first, v_sample, y_second,
//   frame_end) is taken at a rising edge with start high and busy low.
//   Config channel: cfg_data bit 0 sets input_format when cfg_valid and
//   cfg_ready are both high (0 = packed UYVY pair, 1 = Y U V triplet).
//   Write it only while no items are in flight.
//   Results: one RGB pixel per cycle on red/green/blue with last_of_item
//   and image_done, shown for exactly one cycle while strobe is high.
//   The receiver cannot stall; the pipeline never holds back a pixel.
//   Pipeline: the first pixel of an item passes through the registered issue,
//   multiply, sum and clamp stages, in that order, before it is on the ports.
//   Throughput: triplet mode takes one item per cycle; UYVY mode takes no
//   new item until its second pixel issues, since its two pixels share the
//   single multiplier bank and busy is high while the second pixel issues.
//   Reset: arst_n low clears all valid bits, the pending second pixel and
//   sets input_format to UYVY; no pixels are emitted until new items.
`default_nettype none

`include "uyvy_yuv_to_rgb_converter_core_defines.svh"

module uyvy_yuv_to_rgb_converter_core #(
	parameter int COEF_FRAC_BITS = uyc_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// command channel
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] u_sample,
	input  wire logic [7:0] y_first,
	input  wire logic [7:0] v_sample,
	input  wire logic [7:0] y_second,
	input  wire logic       frame_end,
	// config channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	// results
	output logic            strobe,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue,
	output logic            last_of_item,
	output logic            image_done
);

	localparam int COEF_W = COEF_FRAC_BITS + 3;
	localparam int PROD_W = COEF_W + 9;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic signed [COEF_W-1:0] C_Y  =
		COEF_W'(uyc_pkg::coef_milli(uyc_pkg::Y_MILLI, COEF_FRAC_BITS));
	localparam logic signed [COEF_W-1:0] C_RV =
		COEF_W'(uyc_pkg::coef_milli(uyc_pkg::RV_MILLI, COEF_FRAC_BITS));
	localparam logic signed [COEF_W-1:0] C_GV =
		COEF_W'(uyc_pkg::coef_milli(uyc_pkg::GV_MILLI, COEF_FRAC_BITS));
	localparam logic signed [COEF_W-1:0] C_GU =
		COEF_W'(uyc_pkg::coef_milli(uyc_pkg::GU_MILLI, COEF_FRAC_BITS));
	localparam logic signed [COEF_W-1:0] C_BU =
		COEF_W'(uyc_pkg::coef_milli(uyc_pkg::BU_MILLI, COEF_FRAC_BITS));

	localparam logic signed [8:0] LY_OFS = 9'(uyc_pkg::LUMA_OFFSET);
	localparam logic signed [8:0] CH_OFS = 9'(uyc_pkg::CHROMA_OFFSET);
	localparam logic [7:0]        CH_MAX = 8'(uyc_pkg::CHAN_MAX);

	// configuration and pending second pixel
	logic       fmt_q;
	logic       pend_valid_q;
	logic [7:0] pend_y_q, pend_u_q, pend_v_q;
	logic       pend_fe_q;

	logic       accept;

	// issue stage
	logic       valid_s1;
	logic [7:0] y_s1, u_s1, v_s1;
	logic       last_s1, done_s1;

	// multiply stage
	logic                     valid_s2, last_s2, done_s2;
	logic signed [PROD_W-1:0] base_s2, prv_s2, pgv_s2, pgu_s2, pbu_s2;

	// sum stage
	logic                    valid_s3, last_s3, done_s3;
	logic signed [SUM_W-1:0] r_sum_s3, g_sum_s3, b_sum_s3;

	// clamp / output stage
	logic       valid_s4, last_s4, done_s4;
	logic [7:0] r_s4, g_s4, b_s4;

	logic signed [8:0] ly, cu, cv;

	assign busy      = pend_valid_q;
	assign accept    = start && !busy;
	assign cfg_ready = !pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= uyc_pkg::FMT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	// hold the second UYVY pixel until it is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else begin
			pend_valid_q <= accept && (fmt_q == uyc_pkg::FMT_UYVY);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_y_q  <= y_second;
			pend_u_q  <= u_sample;
			pend_v_q  <= v_sample;
			pend_fe_q <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= pend_valid_q || accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// issue: pending second pixel first, else the new transaction
	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			y_s1    <= pend_y_q;
			u_s1    <= pend_u_q;
			v_s1    <= pend_v_q;
			last_s1 <= 1'b1;
			done_s1 <= pend_fe_q;
		end else begin
			y_s1    <= y_first;
			u_s1    <= u_sample;
			v_s1    <= v_sample;
			last_s1 <= (fmt_q == uyc_pkg::FMT_TRIPLET);
			done_s1 <= (fmt_q == uyc_pkg::FMT_TRIPLET) && frame_end;
		end
	end

	assign ly = $signed({1'b0, y_s1}) - LY_OFS;
	assign cu = $signed({1'b0, u_s1}) - CH_OFS;
	assign cv = $signed({1'b0, v_s1}) - CH_OFS;

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		done_s2 <= done_s1;
		base_s2 <= PROD_W'(C_Y) * PROD_W'(ly);
		prv_s2  <= PROD_W'(C_RV) * PROD_W'(cv);
		pgv_s2  <= PROD_W'(C_GV) * PROD_W'(cv);
		pgu_s2  <= PROD_W'(C_GU) * PROD_W'(cu);
		pbu_s2  <= PROD_W'(C_BU) * PROD_W'(cu);
	end

	always_ff @(posedge clk) begin
		last_s3  <= last_s2;
		done_s3  <= done_s2;
		r_sum_s3 <= SUM_W'(base_s2) + SUM_W'(prv_s2);
		g_sum_s3 <= SUM_W'(base_s2) - SUM_W'(pgv_s2) - SUM_W'(pgu_s2);
		b_sum_s3 <= SUM_W'(base_s2) + SUM_W'(pbu_s2);
	end

	// negative gives 0, anything above the 8 integer bits saturates
	function automatic logic [7:0] clamp_chan(input logic signed [SUM_W-1:0] sum);
		logic [7:0] res;
		if (sum[SUM_W-1]) begin
			res = 8'd0;
		end else if (sum[SUM_W-2:COEF_FRAC_BITS+8] != '0) begin
			res = CH_MAX;
		end else begin
			res = sum[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		last_s4 <= last_s3;
		done_s4 <= done_s3;
		r_s4    <= clamp_chan(r_sum_s3);
		g_s4    <= clamp_chan(g_sum_s3);
		b_s4    <= clamp_chan(b_sum_s3);
	end

	assign strobe       = valid_s4;
	assign red          = r_s4;
	assign green        = g_s4;
	assign blue         = b_s4;
	assign last_of_item = last_s4;
	assign image_done   = done_s4;

	`UYC_ASSERT_NEXT(a_busy_one_cycle, clk, arst_n, busy, !busy, "busy held two cycles")
	`UYC_ASSERT_NEXT(a_uyvy_sets_busy, clk, arst_n, accept && (fmt_q == uyc_pkg::FMT_UYVY), busy, "UYVY transaction did not hold busy")
	`UYC_ASSERT(a_latency, clk, arst_n, accept |-> ##4 strobe, "pixel missing four cycles after transaction")
	`UYC_ASSERT_NEXT(a_pair_follows, clk, arst_n, strobe && !last_of_item, strobe && last_of_item, "second pixel of pair missing")
	`UYC_ASSERT(a_done_is_last, clk, arst_n, (strobe && image_done) |-> last_of_item, "image_done on a non-final pixel")

endmodule

`default_nettype wire
